### design/ddrd_pkg.sv
// Shared types, constants and register codes of the depth drop run detector.
package ddrd_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 2048;
  localparam int unsigned MAX_ROWS        = 2048;
  localparam int unsigned COL_W_MAX       = 13;
  localparam int unsigned CFG_IDX_W       = 4;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned FIFO_DEPTH      = 4;
  localparam int unsigned DIV_N_W         = 37;
  localparam int unsigned DIV_D_W         = 18;

  localparam logic [CFG_IDX_W-1:0] REG_DROP_THR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW = 4'd7;

  typedef struct packed {
    logic [15:0] drop_threshold_mm;
    logic [10:0] min_width_px;
    logic [10:0] max_width_px;
    logic [15:0] focal_x_q4;
    logic [15:0] focal_y_q4;
    logic [11:0] center_x_half;
    logic [11:0] center_y_half;
    logic [10:0] first_scan_row;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    drop_threshold_mm: 16'd250,
    min_width_px:      11'd20,
    max_width_px:      11'd200,
    focal_x_q4:        16'd8400,
    focal_y_q4:        16'd8400,
    center_x_half:     12'd639,
    center_y_half:     12'd479,
    first_scan_row:    11'd240
  };

  // One closed run waiting for the arithmetic back end.
  typedef struct packed {
    logic [COL_W_MAX-1:0] u;
    logic [COL_W_MAX-1:0] wpx;
    logic [10:0]          row;
    logic [15:0]          z;
    logic signed [16:0]   drop;
    logic signed [17:0]   conf_num;
  } rep_t;

  typedef struct packed {
    logic start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/ddrd_if.sv
// Channel interfaces: pixel input, report output and configuration write.
interface ddrd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_mm;
  logic        depth_valid;
  logic [10:0] row;
  logic        row_end;
  modport source (output valid, depth_mm, depth_valid, row, row_end, input ready);
  modport sink   (input valid, depth_mm, depth_valid, row, row_end, output ready);
endinterface

interface ddrd_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x_mm;
  logic signed [23:0] pos_y_mm;
  logic        [15:0] pos_z_mm;
  logic        [22:0] width_mm;
  logic signed [16:0] drop_mm;
  logic signed [16:0] confidence_q8;
  modport source (output valid, pos_x_mm, pos_y_mm, pos_z_mm, width_mm, drop_mm,
                  confidence_q8, input ready);
  modport sink   (input valid, pos_x_mm, pos_y_mm, pos_z_mm, width_mm, drop_mm,
                  confidence_q8, output ready);
endinterface

interface ddrd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ddrd_pkg::CFG_IDX_W-1:0]   index;
  logic [ddrd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/ddrd_fifo.sv
// Small register queue between the pixel front end and the arithmetic back end.
module ddrd_fifo #(
  parameter type T = ddrd_pkg::rep_t,
  parameter int unsigned DEPTH = ddrd_pkg::FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T                mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

### design/ddrd_front.sv
// Pixel front end: pairs pixels, tracks runs and queues closed runs.
module ddrd_front #(
  parameter int unsigned MAX_COLUMNS = ddrd_pkg::MAX_COLUMNS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ddrd_pkg::cfg_t  cfg_i,
  ddrd_in_if.sink         in_if,
  input  logic            q_full_i,
  output logic            push_o,
  output ddrd_pkg::rep_t  rep_o
);
  localparam int unsigned CW = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned XW = ddrd_pkg::COL_W_MAX;

  logic [15:0]   last_depth_q;
  logic          last_valid_q;
  logic          run_open_q;
  logic [CW-1:0] start_q;
  logic [15:0]   ref_q;
  logic [CW-1:0] col_q;

  logic               accept, row_ok, examine, open_c, close_c, report;
  logic signed [17:0] step, thr;
  logic [CW-1:0]      wpx;
  logic [XW-1:0]      wpx_x;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;

  assign row_ok  = (in_if.row >= cfg_i.first_scan_row) &&
                   (int'(in_if.row) < int'(ddrd_pkg::MAX_ROWS));
  assign examine = (col_q != '0) && row_ok && last_valid_q && in_if.depth_valid;
  assign step    = $signed({2'b00, in_if.depth_mm}) - $signed({2'b00, last_depth_q});
  assign thr     = $signed({2'b00, cfg_i.drop_threshold_mm});
  assign open_c  = (step > thr) && !run_open_q;
  assign close_c = run_open_q && ((step < -thr) || in_if.row_end);
  assign wpx     = col_q - start_q;
  assign wpx_x   = XW'(wpx);
  assign report  = accept && examine && !open_c && close_c &&
                   (wpx_x >= XW'(cfg_i.min_width_px)) && (wpx_x <= XW'(cfg_i.max_width_px));

  assign push_o         = report;
  assign rep_o.u        = XW'(start_q + (wpx >> 1));
  assign rep_o.wpx      = wpx_x;
  assign rep_o.row      = in_if.row;
  assign rep_o.z        = ref_q;
  assign rep_o.drop     = 17'($signed({1'b0, in_if.depth_mm}) - $signed({1'b0, ref_q}));
  assign rep_o.conf_num = step - thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_depth_q <= '0;
      last_valid_q <= 1'b0;
      run_open_q   <= 1'b0;
      start_q      <= '0;
      ref_q        <= '0;
      col_q        <= '0;
    end else if (accept) begin
      last_depth_q <= in_if.depth_mm;
      last_valid_q <= in_if.depth_valid;
      if (examine && open_c) begin
        run_open_q <= 1'b1;
        start_q    <= col_q;
        ref_q      <= last_depth_q;
      end else if (examine && close_c) begin
        run_open_q <= 1'b0;
      end
      if (in_if.row_end) begin
        run_open_q <= 1'b0;
        col_q      <= '0;
      end else if (col_q < CW'(MAX_COLUMNS - 1)) begin
        col_q <= col_q + 1'b1;
      end
    end
  end
endmodule

### design/ddrd_div.sv
// Restoring divider, one quotient bit per cycle.
module ddrd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddrd_pkg::div_req_t req_i,
  output ddrd_pkg::div_rsp_t rsp_o
);
  localparam int unsigned NW = ddrd_pkg::DIV_N_W;
  localparam int unsigned DW = ddrd_pkg::DIV_D_W;

  logic          busy_q, done_q;
  logic [5:0]    cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

### design/ddrd_back.sv
// Arithmetic back end: projects a queued run into a report through one divider.
module ddrd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddrd_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  ddrd_pkg::rep_t     rep_i,
  output logic               pop_o,
  output ddrd_pkg::div_req_t div_req_o,
  input  ddrd_pkg::div_rsp_t div_rsp_i,
  ddrd_out_if.source         out_if
);
  localparam int unsigned NW = ddrd_pkg::DIV_N_W;
  // 2^34 / 500 rounded up; exact quotient for every dividend below 2^25.
  localparam logic [25:0] RECIP_500 = 26'd34359739;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_START, S_WAIT, S_OUT} state_e;
  typedef enum logic [1:0] {OP_X, OP_Y, OP_W, OP_C} op_e;

  state_e             state_q;
  op_e                op_q;
  ddrd_pkg::rep_t     ent_q;
  logic signed [33:0] prod_q;
  logic               neg_q;
  logic signed [23:0] x_q, y_q;
  logic [22:0]        w_q;
  logic signed [16:0] c_q;
  logic               out_valid_q;

  logic signed [15:0] fac;
  logic signed [41:0] num;
  logic [41:0]        mag;
  logic [15:0]        den, fx, fy;
  logic [NW-1:0]      q, qn;
  logic signed [23:0] xy_sat;
  logic               cneg;
  logic [16:0]        cmag;
  logic [25:0]        cnum;
  logic [51:0]        cprod;
  logic [17:0]        cq;
  logic signed [16:0] c_sat;

  assign fx = (cfg_i.focal_x_q4 == '0) ? 16'd1 : cfg_i.focal_x_q4;
  assign fy = (cfg_i.focal_y_q4 == '0) ? 16'd1 : cfg_i.focal_y_q4;

  always_comb begin
    fac = '0;
    den = fx;
    num = '0;
    unique case (op_q)
      OP_X: begin
        fac = $signed({2'b00, ent_q.u, 1'b0}) - $signed({4'b0, cfg_i.center_x_half});
        num = 42'(prod_q) <<< 3;
      end
      OP_Y: begin
        fac = $signed({4'b0, ent_q.row, 1'b0}) - $signed({4'b0, cfg_i.center_y_half});
        den = fy;
        num = 42'(prod_q) <<< 3;
      end
      OP_W: begin
        fac = $signed({3'b0, ent_q.wpx});
        num = 42'(prod_q) <<< 4;
      end
      default: ;
    endcase
  end

  assign mag = num[41] ? 42'(-num) : 42'(num);
  assign q   = div_rsp_i.quotient;
  assign qn  = NW'(-q);

  assign xy_sat = (!neg_q && q > NW'(8388607)) ? 24'h7FFFFF :
                  (neg_q && q > NW'(8388608))  ? 24'h800000 :
                  (neg_q ? 24'(qn) : 24'(q));

  // Confidence: round the magnitude of (step - threshold) * 256 / 500 by a
  // reciprocal multiply, then restore the sign and clamp.
  assign cneg  = ent_q.conf_num[17];
  assign cmag  = cneg ? 17'(-ent_q.conf_num) : 17'(ent_q.conf_num);
  assign cnum  = {1'b0, cmag, 8'b0} + 26'd250;
  assign cprod = cnum * RECIP_500;
  assign cq    = cprod[51:34];
  assign c_sat = (!cneg && cq > 18'd256)  ? 17'd256 :
                 (cneg && cq > 18'd65536) ? 17'h10000 :
                 (cneg ? 17'(-cq) : 17'(cq));

  assign div_req_o.start    = (state_q == S_START);
  assign div_req_o.dividend = NW'({mag, 1'b0} + 43'(den));
  assign div_req_o.divisor  = {1'b0, den, 1'b0};

  assign pop_o = (state_q == S_IDLE) && !q_empty_i;

  assign out_if.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= S_IDLE;
      op_q                 <= OP_X;
      ent_q                <= '0;
      prod_q               <= '0;
      neg_q                <= 1'b0;
      x_q                  <= '0;
      y_q                  <= '0;
      w_q                  <= '0;
      c_q                  <= '0;
      out_valid_q          <= 1'b0;
      out_if.pos_x_mm      <= '0;
      out_if.pos_y_mm      <= '0;
      out_if.pos_z_mm      <= '0;
      out_if.width_mm      <= '0;
      out_if.drop_mm       <= '0;
      out_if.confidence_q8 <= '0;
    end else begin
      if (state_q == S_OUT && (!out_valid_q || out_if.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            ent_q   <= rep_i;
            op_q    <= OP_X;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (op_q == OP_C) begin
            c_q     <= c_sat;
            state_q <= S_OUT;
          end else begin
            prod_q  <= 34'(fac * $signed({1'b0, ent_q.z}));
            state_q <= S_START;
          end
        end
        S_START: begin
          neg_q   <= num[41];
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp_i.done) begin
            unique case (op_q)
              OP_X:    x_q <= xy_sat;
              OP_Y:    y_q <= xy_sat;
              OP_W:    w_q <= (q > NW'(8388607)) ? 23'h7FFFFF : 23'(q);
              default: ;
            endcase
            op_q    <= op_e'(op_q + 2'd1);
            state_q <= S_MUL;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_if.ready) begin
            out_if.pos_x_mm      <= x_q;
            out_if.pos_y_mm      <= y_q;
            out_if.pos_z_mm      <= ent_q.z;
            out_if.width_mm      <= w_q;
            out_if.drop_mm       <= ent_q.drop;
            out_if.confidence_q8 <= c_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### design/depth_drop_run_detector_top.sv
// Top level of the depth drop run detector: registers, front end, queue, back end.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+-------------------------------------------
//  in_if    | in  | valid/ready        | depth_mm, depth_valid, row, row_end
//  out_if   | out | valid/ready        | pos_x/y/z_mm, width_mm, drop_mm, confidence_q8
//  cfg_if   | in  | valid/ready (=1)   | index, data
//
// The front end takes one pixel word per cycle; ready drops only while the
// four-entry run queue is full. A report holds the back end through a pop,
// three divisions on the single restoring divider (multiply, start, 37
// bits, done), a reciprocal multiply for confidence and an output state. Reset
// clears all run state and loads the register defaults; there is no clearing
// pass. A stalled output holds the back end while the queue keeps pixels flowing.
module depth_drop_run_detector_top #(
  parameter int unsigned MAX_COLUMNS = ddrd_pkg::MAX_COLUMNS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddrd_in_if.sink    in_if,
  ddrd_out_if.source out_if,
  ddrd_cfg_if.sink   cfg_if
);
  ddrd_pkg::cfg_t     cfg_q;
  ddrd_pkg::rep_t     push_data, pop_data;
  ddrd_pkg::div_req_t div_req;
  ddrd_pkg::div_rsp_t div_rsp;
  logic               push, pop, q_full, q_empty;

  // Always take register writes; mask to the register width.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ddrd_pkg::CFG_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        ddrd_pkg::REG_DROP_THR:  cfg_q.drop_threshold_mm <= cfg_if.data;
        ddrd_pkg::REG_MIN_WIDTH: cfg_q.min_width_px      <= cfg_if.data[10:0];
        ddrd_pkg::REG_MAX_WIDTH: cfg_q.max_width_px      <= cfg_if.data[10:0];
        ddrd_pkg::REG_FOCAL_X:   cfg_q.focal_x_q4        <= cfg_if.data;
        ddrd_pkg::REG_FOCAL_Y:   cfg_q.focal_y_q4        <= cfg_if.data;
        ddrd_pkg::REG_CENTER_X:  cfg_q.center_x_half     <= cfg_if.data[11:0];
        ddrd_pkg::REG_CENTER_Y:  cfg_q.center_y_half     <= cfg_if.data[11:0];
        ddrd_pkg::REG_FIRST_ROW: cfg_q.first_scan_row    <= cfg_if.data[10:0];
        default: ;
      endcase
    end
  end

  ddrd_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_if,
    .q_full_i(q_full), .push_o(push), .rep_o(push_data)
  );

  ddrd_fifo #(.T(ddrd_pkg::rep_t), .DEPTH(ddrd_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .data_o(pop_data)
  );

  ddrd_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  ddrd_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_empty_i(q_empty), .rep_i(pop_data),
    .pop_o(pop), .div_req_o(div_req), .div_rsp_i(div_rsp), .out_if
  );
endmodule
